### sv/rational_accumulator_alu_macros.svh
// assertion macros used by the checker file
`ifndef RATIONAL_ACCUMULATOR_ALU_MACROS_SVH
`define RATIONAL_ACCUMULATOR_ALU_MACROS_SVH

// property checked on every rising edge outside reset
`define RAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define RAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rac_pkg.sv
// types, codes and helpers for the rational accumulator
package rac_pkg;

  localparam int WORD_W  = 32;
  localparam int FIELD_W = 32;
  localparam int CNT_W   = $clog2(WORD_W);

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_SUB  = 2'd2,
    ACT_MUL  = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_CHECK,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_DONE
  } state_t;

  // request to a shared iterative unit
  typedef struct packed {
    logic  start;
    word_t opa;
    word_t opb;
  } rac_req_t;

  // status back from a shared iterative unit
  typedef struct packed {
    logic  done;
    word_t value;
  } rac_sts_t;

  // magnitude of a two's complement word, most negative value included
  function automatic word_t mag(input word_t v);
    mag = v[WORD_W-1] ? (~v + word_t'(1)) : v;
  endfunction

endpackage

### sv/rac_gcd.sv
// iterative binary gcd of two nonzero magnitudes, one step per cycle
module rac_gcd import rac_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rac_req_t req,
  output rac_sts_t sts
);

  word_t a_r, b_r;
  cnt_t  k_r;
  logic  busy_r;
  logic  finish;

  // both odd and equal: odd part found
  assign finish    = busy_r && a_r[0] && b_r[0] && (a_r == b_r);
  assign sts.done  = finish;
  assign sts.value = a_r << k_r;

  // stein step: strip twos, then subtract smaller from larger
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      a_r    <= req.opa;
      b_r    <= req.opb;
      k_r    <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      priority if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + cnt_t'(1);
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r == b_r) begin
        busy_r <= 1'b0;
      end else if (a_r > b_r) begin
        a_r <= a_r - b_r;
      end else begin
        b_r <= b_r - a_r;
      end
    end
  end

endmodule

### sv/rac_div.sv
// restoring unsigned divider, one quotient bit per cycle
module rac_div import rac_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rac_req_t req,
  output rac_sts_t sts
);

  word_t              q_r, d_r, rem_r;
  cnt_t               cnt_r;
  logic               busy_r, done_r;
  logic [WORD_W:0]    trial;
  logic               fits;

  // shift next dividend bit into the partial remainder
  assign trial = {rem_r, q_r[WORD_W-1]};
  assign fits  = trial >= {1'b0, d_r};

  assign sts.done  = done_r;
  assign sts.value = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      q_r    <= req.opa;
      d_r    <= req.opb;
      rem_r  <= '0;
      cnt_r  <= cnt_t'(WORD_W - 1);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= fits ? word_t'(trial - {1'b0, d_r}) : trial[WORD_W-1:0];
      q_r   <= {q_r[WORD_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - cnt_t'(1);
      end
    end else begin
      done_r <= 1'b0;
    end
  end

endmodule

### sv/rational_accumulator_alu.sv
// top level: rational accumulator with gcd reduction
//
// Keeps one fraction numerator/denominator. Each request on the in_ channel
// loads a fraction, or adds, subtracts or multiplies one into the accumulator;
// each request gives exactly one result on the out_ channel, the accumulator
// after the step. Both channels use valid/ready.
// in_ready is high only while the sequencer is idle; one request is worked on
// at a time. A load goes straight to the commit state. An arithmetic request
// takes three products on the shared multiplier, one zero check, the binary
// gcd loop and two restoring divisions on the shared divider, then a commit;
// a zero part skips the gcd and the divisions. The sequencer then returns to
// idle before the next request is taken.
// The result sits in an output register; a new request is taken while it waits.
// A stalled receiver holds the finished next result in the sequencer until the
// waiting one is taken; the accumulator is updated only then.
// Reset (rst_n low, synchronous) sets the accumulator to 0/1 and empties the
// output register.
module rational_accumulator_alu import rac_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic signed [FIELD_W-1:0] in_other_numerator,
  input  logic signed [FIELD_W-1:0] in_other_denominator,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [FIELD_W-1:0] out_result_numerator,
  output logic signed [FIELD_W-1:0] out_result_denominator
);

  state_t   state_r, state_nxt;
  act_t     act_r;
  word_t    x_r, y_r, acc_num_r, acc_den_r;
  word_t    t1_r, t2_r, nn_r, dd_r, g_r;
  logic     out_valid_r;
  word_t    mul_a, mul_b, prod;
  logic     in_fire, done_fire, part_zero;
  rac_req_t gcd_req, div_req;
  rac_sts_t gcd_sts, div_sts;

  assign in_fire   = in_valid && in_ready;
  assign done_fire = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign part_zero = (nn_r == '0) || (dd_r == '0);

  // shared multiplier, low word kept
  assign prod = mul_a * mul_b;

  rac_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gcd_req),
    .sts   (gcd_sts)
  );

  rac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = (act_t'(in_action) == ACT_LOAD) ? S_DONE : S_MUL1;
      end
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_MUL3;
      S_MUL3:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = part_zero ? S_DONE : S_GCD;
      S_GCD:   if (gcd_sts.done) state_nxt = S_DIVN;
      S_DIVN:  if (div_sts.done) state_nxt = S_DIVD;
      S_DIVD:  if (div_sts.done) state_nxt = S_DONE;
      S_DONE:  if (done_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: operand selection and unit starts
  always_comb begin
    in_ready      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    gcd_req.start = 1'b0;
    gcd_req.opa   = mag(nn_r);
    gcd_req.opb   = mag(dd_r);
    div_req.start = 1'b0;
    div_req.opa   = mag(nn_r);
    div_req.opb   = gcd_sts.value;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_MUL1: begin
        mul_a = acc_num_r;
        mul_b = (act_r == ACT_MUL) ? x_r : y_r;
      end
      S_MUL2: begin
        mul_a = x_r;
        mul_b = acc_den_r;
      end
      S_MUL3: begin
        mul_a = acc_den_r;
        mul_b = y_r;
      end
      S_CHECK: gcd_req.start = !part_zero;
      S_GCD:   div_req.start = gcd_sts.done;
      S_DIVN: begin
        div_req.start = div_sts.done;
        div_req.opa   = mag(dd_r);
        div_req.opb   = g_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // request capture and working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_r <= act_t'(in_action);
          x_r   <= word_t'(in_other_numerator);
          y_r   <= word_t'(in_other_denominator);
          nn_r  <= word_t'(in_other_numerator);
          dd_r  <= word_t'(in_other_denominator);
        end
      end
      S_MUL1: t1_r <= prod;
      S_MUL2: t2_r <= prod;
      S_MUL3: begin
        dd_r <= prod;
        unique case (act_r)
          ACT_ADD: nn_r <= t1_r + t2_r;
          ACT_SUB: nn_r <= t1_r - t2_r;
          default: nn_r <= t1_r;
        endcase
      end
      S_CHECK: begin
        if (part_zero) begin
          nn_r <= '0;
          dd_r <= '0;
        end
      end
      S_GCD: if (gcd_sts.done) g_r <= gcd_sts.value;
      S_DIVN: begin
        if (div_sts.done) begin
          nn_r <= nn_r[WORD_W-1] ? (~div_sts.value + word_t'(1)) : div_sts.value;
        end
      end
      S_DIVD: begin
        if (div_sts.done) begin
          dd_r <= dd_r[WORD_W-1] ? (~div_sts.value + word_t'(1)) : div_sts.value;
        end
      end
      default: ;
    endcase
  end

  // accumulator commit and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_num_r   <= '0;
      acc_den_r   <= word_t'(1);
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      acc_num_r   <= nn_r;
      acc_den_r   <= dd_r;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_result_numerator   = FIELD_W'(signed'(acc_num_r));
  assign out_result_denominator = FIELD_W'(signed'(acc_den_r));

endmodule

### sv/rac_checker.sv
// port-level checks for the rational accumulator, bound to the top level
`include "rational_accumulator_alu_macros.svh"

module rac_checker import rac_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_action,
  input logic signed [FIELD_W-1:0] in_other_numerator,
  input logic signed [FIELD_W-1:0] in_other_denominator,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [FIELD_W-1:0] out_result_numerator,
  input logic signed [FIELD_W-1:0] out_result_denominator
);

  logic [2*FIELD_W-1:0] out_payload;

  // both result fields side by side
  assign out_payload = {out_result_numerator, out_result_denominator};

  // an accepted request keeps the block busy for at least the next cycle
  `RAC_ASSERT(a_busy_after_req, in_valid && in_ready |=> !in_ready, "ready after request")

  // a new result appears only as the sequencer leaves its busy time
  `RAC_ASSERT(a_result_from_busy, $rose(out_valid) |-> !$past(in_ready), "result while idle")

  // a waiting result holds until taken
  `RAC_ASSERT(a_hold_valid, out_valid && !out_ready |=> out_valid, "result dropped")

  // a waiting result keeps its fields
  `RAC_ASSERT(a_hold_data, out_valid && !out_ready |=> $stable(out_payload), "result changed")

  // reset empties the output register
  `RAC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind rational_accumulator_alu rac_checker u_rac_checker (.*);
